// ----- design/pfla_pkg.sv -----
// pfla_pkg: shared widths, operation and status codes for the page allocator.
// No dependencies; imported by pfla_addr_chk and page_free_list_allocator.
package pfla_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned CFG_W   = 29;
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned REF_W   = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // reset values of the configuration registers
  localparam logic [CFG_W-1:0] FREE_BASE_RST = 29'd0;
  localparam logic [CFG_W-1:0] PHYS_TOP_RST  = 29'd234881024;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FREE_BASE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_PHYS_TOP  = 2'd1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO     = 2'd3;

endpackage

// ----- design/pfla_ram.sv -----
// pfla_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module pfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pfla_addr_chk.sv -----
// pfla_addr_chk: page address check (alignment, [free_base, phys_top), page range).
// Depends on pfla_pkg.
module pfla_addr_chk #(
  parameter int unsigned MAX_PAGES  = 65536,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic [pfla_pkg::ADDR_W-1:0] addr_i,
  input  logic [pfla_pkg::CFG_W-1:0]  free_base_i,
  input  logic [pfla_pkg::CFG_W-1:0]  phys_top_i,
  output logic                        good_o
);
  import pfla_pkg::*;

  localparam int unsigned PNW = ADDR_W - PAGE_SHIFT;
  localparam logic [ADDR_W:0] PAGE_LIM = (ADDR_W + 1)'(MAX_PAGES);

  logic [PNW-1:0] page_num;
  logic           aligned;
  logic           above_base;
  logic           below_top;
  logic           in_range;

  assign page_num   = addr_i[ADDR_W-1:PAGE_SHIFT];
  assign aligned    = (addr_i[PAGE_SHIFT-1:0] == '0);
  assign above_base = (addr_i >= ADDR_W'(free_base_i));
  assign below_top  = (addr_i < ADDR_W'(phys_top_i));
  assign in_range   = ((ADDR_W + 1)'(page_num) < PAGE_LIM);
  assign good_o     = aligned & above_base & below_top & in_range;

endmodule

// ----- design/page_free_list_allocator.sv -----
// page_free_list_allocator: LIFO free-list page allocator with per-page refcounts.
// Depends on pfla_pkg, pfla_ram, pfla_addr_chk.
//
//  channel | direction | signals                                   | handshake
//  --------+-----------+-------------------------------------------+--------------------------
//  command | in        | operation_i, page_addr_i                  | start & !busy
//  result  | out       | status_o, result_addr_o, page_freed_o,    | done_o, one cycle,
//          |           | free_count_o                              | no backpressure
//  config  | in        | cfg_index_i, cfg_data_i                   | cfg_valid_i & cfg_ready_o
//
// For each item, the accept edge launches the reads of the next-page and refcount
// RAMs, and the following edge does the update and write-back and registers the
// result together with done_o.
// A new item may be accepted in the same cycle that result is shown.
// After reset the refcount RAM is cleared one entry per cycle: busy stays high
// until every entry is cleared. Config writes are always taken (cfg_ready_o tied high).
module page_free_list_allocator #(
  parameter int unsigned MAX_PAGES  = 65536,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic [pfla_pkg::OP_W-1:0]     operation_i,
  input  logic [pfla_pkg::ADDR_W-1:0]   page_addr_i,
  // result
  output logic                          done_o,
  output logic [pfla_pkg::STAT_W-1:0]   status_o,
  output logic [pfla_pkg::ADDR_W-1:0]   result_addr_o,
  output logic                          page_freed_o,
  output logic [pfla_pkg::COUNT_W-1:0]  free_count_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfla_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [pfla_pkg::ADDR_W-1:0]   cfg_data_i
);
  import pfla_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PAGES);  // page index width
  localparam int unsigned NW = PW + 1;             // next link: 0 = end, else idx+1
  localparam logic [PW-1:0] LAST_PAGE = PW'(MAX_PAGES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [PW-1:0]      clr_cnt_q, clr_cnt_d;
  logic [PW-1:0]      head_q, head_d;
  logic               head_vld_q, head_vld_d;
  logic [COUNT_W-1:0] pages_free_q, pages_free_d;
  logic               done_q, done_d;
  logic [CFG_W-1:0]   free_base_q, phys_top_q;

  // item payload, no reset
  logic [OP_W-1:0]    op_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [STAT_W-1:0]  status_q, status_d;
  logic [ADDR_W-1:0]  res_q, res_d;
  logic               freed_q, freed_d;

  // RAM ports
  logic               nxt_we;
  logic [NW-1:0]      nxt_wdata;
  logic [NW-1:0]      nxt_rdata;
  logic               ref_we;
  logic [PW-1:0]      ref_waddr;
  logic [REF_W-1:0]   ref_wdata;
  logic [REF_W-1:0]   ref_rdata;

  logic               accept;
  logic [PW-1:0]      in_idx;
  logic [PW-1:0]      item_idx;
  logic               addr_good;
  logic               push;
  logic [REF_W-1:0]   ref_dec;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;

  assign in_idx   = PW'(page_addr_i >> PAGE_SHIFT);
  assign item_idx = PW'(addr_q >> PAGE_SHIFT);
  assign ref_dec  = ref_rdata - REF_W'(1);

  // next-page links; read at the head on accept
  pfla_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_PAGES)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (item_idx),
    .wdata_i (nxt_wdata),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (nxt_rdata)
  );

  // reference counts; read at the item's page on accept
  pfla_ram #(
    .WIDTH (REF_W),
    .DEPTH (MAX_PAGES)
  ) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (ref_rdata)
  );

  pfla_addr_chk #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_addr_chk (
    .addr_i      (addr_q),
    .free_base_i (free_base_q),
    .phys_top_i  (phys_top_q),
    .good_o      (addr_good)
  );

  // push of the item's page: good free, or release that reaches zero
  always_comb begin
    push = 1'b0;
    if (state_q == ST_EXEC && addr_good) begin
      case (op_q)
        OP_FREE:    push = 1'b1;
        OP_RELEASE: push = (ref_rdata != '0) && (ref_dec == '0);
        default:    push = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    head_d       = head_q;
    head_vld_d   = head_vld_q;
    pages_free_d = pages_free_q;
    done_d       = 1'b0;
    status_d     = STAT_OK;
    res_d        = '0;
    freed_d      = 1'b0;
    nxt_we       = 1'b0;
    nxt_wdata    = head_vld_q ? NW'(head_q) + NW'(1) : '0;
    ref_we       = 1'b0;
    ref_waddr    = item_idx;
    ref_wdata    = ref_dec;

    case (state_q)
      ST_CLEAR: begin
        ref_we    = 1'b1;
        ref_waddr = clr_cnt_q;
        ref_wdata = '0;
        clr_cnt_d = clr_cnt_q + PW'(1);
        if (clr_cnt_q == LAST_PAGE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        case (op_q)
          OP_ALLOC: begin
            if (head_vld_q) begin
              res_d     = ADDR_W'({head_q, {PAGE_SHIFT{1'b0}}});
              ref_we    = 1'b1;
              ref_waddr = head_q;
              ref_wdata = REF_W'(1);
              if (nxt_rdata == '0) begin
                head_vld_d = 1'b0;
                head_d     = '0;
              end else begin
                head_d = PW'(nxt_rdata - NW'(1));
              end
              if (pages_free_q != '0) begin
                pages_free_d = pages_free_q - COUNT_W'(1);
              end
            end else begin
              status_d = STAT_EMPTY;
            end
          end
          OP_FREE: begin
            if (!addr_good) begin
              status_d = STAT_BAD_ADDR;
            end
          end
          OP_RELEASE: begin
            if (!addr_good) begin
              status_d = STAT_BAD_ADDR;
            end else if (ref_rdata == '0) begin
              status_d = STAT_ZERO;
            end else begin
              ref_we  = 1'b1;
              freed_d = push;
            end
          end
          default: ;
        endcase
        if (push) begin
          nxt_we     = 1'b1;
          head_d     = item_idx;
          head_vld_d = 1'b1;
          if (pages_free_q != COUNT_MAX) begin
            pages_free_d = pages_free_q + COUNT_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      head_q       <= '0;
      head_vld_q   <= 1'b0;
      pages_free_q <= '0;
      done_q       <= 1'b0;
      free_base_q  <= FREE_BASE_RST;
      phys_top_q   <= PHYS_TOP_RST;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      head_q       <= head_d;
      head_vld_q   <= head_vld_d;
      pages_free_q <= pages_free_d;
      done_q       <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_FREE_BASE: free_base_q <= cfg_data_i[CFG_W-1:0];
          CFG_PHYS_TOP:  phys_top_q  <= cfg_data_i[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      addr_q <= page_addr_i;
    end
    status_q <= status_d;
    res_q    <= res_d;
    freed_q  <= freed_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_addr_o = res_q;
  assign page_freed_o  = freed_q;
  // count only changes on an execute edge, so it holds through the result cycle
  assign free_count_o  = pages_free_q;

endmodule
